FILE: rtl/frame_rate_moving_average_assert.svh
// assertion macros for the frame rate moving average rtl
`ifndef FRAME_RATE_MOVING_AVERAGE_ASSERT_SVH
`define FRAME_RATE_MOVING_AVERAGE_ASSERT_SVH

// condition that must hold at every edge out of reset
`define FRMAVG_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define FRMAVG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/frmavg_pkg.sv
package frmavg_pkg;

    localparam int RATE_W = 20;
    localparam int TICK_W = 32;

    // sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RATE = 4'b0010,
        ST_AVG  = 4'b0100,
        ST_FIN  = 4'b1000
    } t_state;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

FILE: rtl/frmavg_div.sv
module frmavg_div
    import frmavg_pkg::*;
#(
    parameter int N = 26
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [N-1:0]      i_dividend,
    input  logic [TICK_W-1:0] i_divisor,
    output logic [N-1:0]      o_quotient,
    output t_div_sts          o_sts
);

    localparam int CNT_W = $clog2(N + 1);

    logic [CNT_W-1:0]  r_cnt;
    logic              r_done;
    logic [N-1:0]      r_q;
    logic [TICK_W-1:0] r_rem;
    logic [TICK_W-1:0] r_dvs;

    logic [TICK_W:0]   shifted;
    logic [TICK_W+1:0] diff;
    logic              ge;

    // one restoring step per cycle
    always_comb begin
        shifted = {r_rem, r_q[N-1]};
        diff    = {1'b0, shifted} - {2'b00, r_dvs};
        ge      = !diff[TICK_W+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(N);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_q   <= {r_q[N-2:0], ge};
            r_rem <= ge ? diff[TICK_W-1:0] : shifted[TICK_W-1:0];
        end
    end

    assign o_quotient = r_q;
    assign o_sts.busy = (r_cnt != '0);
    assign o_sts.done = r_done;

endmodule

FILE: rtl/frame_rate_moving_average.sv
// Frame rate moving average. Each input transaction carries the free-running
// tick count seen at one frame; the block forms the instantaneous rate
// tick_rate_hz / (tick_now - previous tick) with a wrapping 32-bit delta
// (rate 0 on a zero delta, the previous tick then kept), keeps the last WINDOW
// rates in a ring with a running sum, and returns one output transaction with
// the truncated mean over the rates stored so far (up to WINDOW). One shared
// restoring divider does both divisions, one quotient bit per cycle, and
// o_stall stays high from acceptance until the result is loaded into the
// output register, so no new frame is taken while one is in work.
// A finished result sits in the output register and a new frame may be
// accepted while it waits. The tick rate register (reset value 1000) is
// written through i_cfg_we / i_cfg_data and should only change while idle.
module frame_rate_moving_average
    import frmavg_pkg::*;
#(
    parameter int WINDOW = 50
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_we,
    input  logic [RATE_W-1:0] i_cfg_data,
    // frame input channel
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [TICK_W-1:0] i_tick_now,
    // average output channel
    output logic              o_valid,
    input  logic              i_stall,
    output logic [RATE_W-1:0] o_avg_rate
);

    localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int SUM_W  = RATE_W + FILL_W;

    t_state             r_state;
    logic [RATE_W-1:0]  r_tick_rate;
    logic [TICK_W-1:0]  r_prev;
    logic [TICK_W-1:0]  r_now;
    logic               r_zero;
    logic [IDX_W-1:0]   r_pos;
    logic [FILL_W-1:0]  r_fill;
    logic [SUM_W-1:0]   r_sum;
    logic [RATE_W-1:0]  r_old;
    logic               r_out_valid;
    logic [RATE_W-1:0]  r_out;

    // ring of stored rates, read once per frame before it is overwritten
    logic [RATE_W-1:0]  rate_ring [WINDOW];

    logic               in_acc;
    logic               out_acc;
    logic               full;
    logic [TICK_W-1:0]  delta;
    logic [RATE_W-1:0]  rate;
    logic [SUM_W-1:0]   n_sum;
    logic [FILL_W-1:0]  n_fill;
    logic [IDX_W-1:0]   n_pos;
    logic               update;
    logic               out_free;
    logic               out_load;

    logic               div_start;
    logic [SUM_W-1:0]   div_dividend;
    logic [TICK_W-1:0]  div_divisor;
    logic [SUM_W-1:0]   div_q;
    t_div_sts           div_sts;

    assign in_acc   = i_valid && !o_stall;
    assign out_acc  = r_out_valid && !i_stall;
    assign out_free = !r_out_valid || !i_stall;
    // finished average moves into the output register
    assign out_load = (r_state == ST_FIN) && out_free;
    assign full     = (r_fill == FILL_W'(WINDOW));
    assign delta    = i_tick_now - r_prev;
    assign update   = (r_state == ST_RATE) && div_sts.done;

    // rate from the first division, forced to zero on a zero delta
    assign rate   = r_zero ? '0 : div_q[RATE_W-1:0];
    // oldest entry leaves the sum only once the ring is full
    assign n_sum  = r_sum - (full ? SUM_W'(r_old) : '0) + SUM_W'(rate);
    assign n_fill = full ? r_fill : r_fill + 1'b1;
    assign n_pos  = (r_pos == IDX_W'(WINDOW - 1)) ? '0 : r_pos + 1'b1;

    // shared divider operands: tick rate / delta first, then sum / fill count
    always_comb begin
        div_start    = in_acc || update;
        div_dividend = SUM_W'(r_tick_rate);
        div_divisor  = delta;
        if (r_state == ST_RATE) begin
            div_dividend = n_sum;
            div_divisor  = TICK_W'(n_fill);
        end
    end

    frmavg_div #(
        .N (SUM_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quotient (div_q),
        .o_sts      (div_sts)
    );

    // sequencer and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tick_rate <= RATE_W'(1000);
            r_prev      <= '0;
            r_pos       <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tick_rate <= i_cfg_data;
            end
            // a new average replaces one taken at the same edge
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_state <= ST_RATE;
                    end
                end
                ST_RATE: begin
                    if (div_sts.done) begin
                        r_sum   <= n_sum;
                        r_fill  <= n_fill;
                        r_pos   <= n_pos;
                        if (!r_zero) begin
                            r_prev <= r_now;
                        end
                        r_state <= ST_AVG;
                    end
                end
                ST_AVG: begin
                    if (div_sts.done) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    // hold the quotient until the output register is free
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_now  <= i_tick_now;
            r_zero <= (delta == '0);
        end
        if (out_load) begin
            r_out <= div_q[RATE_W-1:0];
        end
    end

    // ring memory: registered read at acceptance, write at update
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_old <= rate_ring[r_pos];
        end
        if (update) begin
            rate_ring[r_pos] <= rate;
        end
    end

    assign o_stall    = (r_state != ST_IDLE);
    assign o_valid    = r_out_valid;
    assign o_avg_rate = r_out;

`include "frame_rate_moving_average_assert.svh"

    // fill count saturates at the window length
    `FRMAVG_ASSERT_ALWAYS(a_fill_max, i_clk, i_rst_n, r_fill <= FILL_W'(WINDOW), "fill over window")
    // write slot stays inside the ring
    `FRMAVG_ASSERT_ALWAYS(a_pos_range, i_clk, i_rst_n,
        {1'b0, r_pos} < (IDX_W + 1)'(WINDOW), "ring slot out of range")
    // divider is never restarted mid-division
    `FRMAVG_ASSERT_ALWAYS(a_div_start, i_clk, i_rst_n,
        !(div_start && div_sts.busy), "divider restarted while busy")
    // an accepted frame is followed by the rate division with the input stalled
    `FRMAVG_ASSERT_NEXT(a_busy_after_acc, i_clk, i_rst_n, in_acc,
        o_stall && (r_state == ST_RATE), "no rate division after acceptance")

endmodule
